// File: rtl/acc_cpu_pkg.sv
// Shared types and constants for the accumulator CPU core.
// Holds the request, opcode and controller state encodings and the command and status structs.
// No dependencies.
package acc_cpu_pkg;

  typedef enum logic [1:0] {
    FN_EXEC,
    FN_WRITE,
    FN_READ,
    FN_CLEAR
  } func_t;

  typedef enum logic [3:0] {
    OP_HALT,
    OP_NOT,
    OP_SHL,
    OP_SHR,
    OP_INC,
    OP_DEC,
    OP_JMP,
    OP_JZ,
    OP_LOAD,
    OP_STORE,
    OP_ADD,
    OP_AND,
    OP_OR,
    OP_XOR,
    OP_PRINT,
    OP_READ
  } op_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_F0,
    ST_F1,
    ST_EX,
    ST_OP,
    ST_L1,
    ST_L2,
    ST_S1,
    ST_W0,
    ST_W1,
    ST_R0,
    ST_R1,
    ST_C0,
    ST_DONE
  } state_t;

  // Source of the RAM address for the current cycle.
  typedef enum logic [2:0] {
    MS_PC,
    MS_PC1,
    MS_Y,
    MS_Y1,
    MS_ADDR,
    MS_ADDR1,
    MS_CLR
  } msrc_t;

  // Source of the RAM write byte.
  typedef enum logic [2:0] {
    WS_ZERO,
    WS_VAL_LO,
    WS_VAL_HI,
    WS_ACC_LO,
    WS_ACC_HI
  } wsrc_t;

  localparam logic [1:0] FMT_HEX  = 2'd0;
  localparam logic [1:0] FMT_DEC  = 2'd1;
  localparam logic [1:0] FMT_CHAR = 2'd2;

  localparam logic [11:0] Y_FMT_DEC  = 12'd1;
  localparam logic [11:0] Y_FMT_CHAR = 12'd2;

  typedef struct packed {
    msrc_t mem_src;
    logic  mem_we;
    wsrc_t wsrc;
    logic  take_req;
    logic  latch_lo;
    logic  latch_ins;
    logic  exec;
    logic  clear_regs;
    logic  cap_rbyte;
    logic  load_out;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic clr_last;
  } stat_t;

endpackage

// File: rtl/acc_cpu_req_if.sv
// Request channel of the accumulator CPU core: valid/ready handshake and request fields.
// No dependencies.
interface acc_cpu_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [11:0] address;
  logic [15:0] value;

  modport source (output valid, func, address, value, input ready);
  modport sink (input valid, func, address, value, output ready);
endinterface

// File: rtl/acc_cpu_rsp_if.sv
// Result channel of the accumulator CPU core: valid/ready handshake and result fields.
// No dependencies.
interface acc_cpu_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] acc_value;
  logic [11:0] pc_value;
  logic        halted;
  logic        print_valid;
  logic [1:0]  print_format;
  logic [7:0]  read_byte;

  modport source (output valid, acc_value, pc_value, halted, print_valid, print_format,
                  read_byte, input ready);
  modport sink (input valid, acc_value, pc_value, halted, print_valid, print_format,
                read_byte, output ready);
endinterface

// File: rtl/accumulator_cpu_core.sv
// Accumulator CPU core: top level joining acc_cpu_ctrl and acc_cpu_dp to the channels.
// Takes one request at a time: a new request is not accepted until the last result
// is loaded into the result register. The byte-wide single-port RAM moves each word
// as two bytes. After reset the RAM is swept to zero with ready held low.
module accumulator_cpu_core #(
  parameter int MEM_BYTES = 4096
) (
  input logic         clk,
  input logic         rst,
  acc_cpu_req_if.sink   req,
  acc_cpu_rsp_if.source rsp
);

  acc_cpu_pkg::cmd_t  cmd;
  acc_cpu_pkg::stat_t stat;

  acc_cpu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_func  (req.func),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  acc_cpu_dp #(
    .MEM_BYTES (MEM_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .req_address  (req.address),
    .req_value    (req.value),
    .cmd          (cmd),
    .stat         (stat),
    .acc_value    (rsp.acc_value),
    .pc_value     (rsp.pc_value),
    .halted_out   (rsp.halted),
    .print_valid  (rsp.print_valid),
    .print_format (rsp.print_format),
    .read_byte    (rsp.read_byte)
  );

endmodule

// File: rtl/acc_cpu_dp.sv
// Datapath of the accumulator CPU core: byte RAM, accumulator, PC, fetch and operand
// registers, ALU and result register. Driven by acc_cpu_ctrl; uses acc_cpu_pkg.
module acc_cpu_dp #(
  parameter int MEM_BYTES = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [11:0]         req_address,
  input  logic [15:0]         req_value,
  input  acc_cpu_pkg::cmd_t   cmd,
  output acc_cpu_pkg::stat_t  stat,
  output logic [15:0]         acc_value,
  output logic [11:0]         pc_value,
  output logic                halted_out,
  output logic                print_valid,
  output logic [1:0]          print_format,
  output logic [7:0]          read_byte
);

  localparam int          AW   = $clog2(MEM_BYTES);
  localparam logic [15:0] MB16 = 16'(MEM_BYTES);

  logic [7:0]  mem [MEM_BYTES];
  logic [7:0]  rdata;
  logic [AW-1:0] clr_cnt;
  logic [AW-1:0] idx;
  logic [11:0] a12;
  logic [7:0]  wdata;

  logic [15:0] acc, acc_next;
  logic [11:0] pc, pc_next;
  logic [11:0] addr_r;
  logic [15:0] val_r;
  logic [7:0]  lo_byte;
  logic [15:0] ins;
  logic        halted;
  logic        pvalid;
  logic [1:0]  pfmt;
  logic [7:0]  rbyte;

  acc_cpu_pkg::op_t op;
  logic [11:0] y;
  logic [15:0] operand;
  logic [1:0]  fmt;

  // Reduces a 12-bit address into the RAM; the quotient is below 16, so four
  // conditional subtractions of shifted sizes suffice.
  function automatic logic [AW-1:0] ram_index(input logic [11:0] a);
    logic [15:0] r;
    r = {4'b0, a};
    for (int k = 3; k >= 0; k--) begin
      if (r >= (MB16 << k)) begin
        r = r - (MB16 << k);
      end
    end
    return r[AW-1:0];
  endfunction

  assign op      = acc_cpu_pkg::op_t'(ins[15:12]);
  assign y       = ins[11:0];
  assign operand = {rdata, lo_byte};
  assign fmt     = (y == acc_cpu_pkg::Y_FMT_DEC)  ? acc_cpu_pkg::FMT_DEC :
                   (y == acc_cpu_pkg::Y_FMT_CHAR) ? acc_cpu_pkg::FMT_CHAR :
                   acc_cpu_pkg::FMT_HEX;

  assign stat.op       = op;
  assign stat.clr_last = (clr_cnt == AW'(MEM_BYTES - 1));

  always_comb begin
    unique case (cmd.mem_src)
      acc_cpu_pkg::MS_PC:    a12 = pc;
      acc_cpu_pkg::MS_PC1:   a12 = pc + 12'd1;
      acc_cpu_pkg::MS_Y:     a12 = y;
      acc_cpu_pkg::MS_Y1:    a12 = y + 12'd1;
      acc_cpu_pkg::MS_ADDR:  a12 = addr_r;
      acc_cpu_pkg::MS_ADDR1: a12 = addr_r + 12'd1;
      default:               a12 = '0;
    endcase
  end

  assign idx = (cmd.mem_src == acc_cpu_pkg::MS_CLR) ? clr_cnt : ram_index(a12);

  always_comb begin
    unique case (cmd.wsrc)
      acc_cpu_pkg::WS_VAL_LO: wdata = val_r[7:0];
      acc_cpu_pkg::WS_VAL_HI: wdata = val_r[15:8];
      acc_cpu_pkg::WS_ACC_LO: wdata = acc[7:0];
      acc_cpu_pkg::WS_ACC_HI: wdata = acc[15:8];
      default:                wdata = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[idx] <= wdata;
    end
    rdata <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.mem_src == acc_cpu_pkg::MS_CLR && !stat.clr_last) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  always_comb begin
    acc_next = acc;
    pc_next  = pc;
    if (cmd.clear_regs) begin
      acc_next = '0;
      pc_next  = '0;
    end else if (cmd.exec) begin
      if (op != acc_cpu_pkg::OP_HALT) begin
        pc_next = pc + 12'd2;
      end
      unique case (op)
        acc_cpu_pkg::OP_HALT:  acc_next = acc;
        acc_cpu_pkg::OP_NOT:   acc_next = ~acc;
        acc_cpu_pkg::OP_SHL:   acc_next = (y[11:4] != '0) ? 16'd0 : acc << y[3:0];
        acc_cpu_pkg::OP_SHR:   acc_next = (y[11:4] != '0) ? 16'd0 : acc >> y[3:0];
        acc_cpu_pkg::OP_INC:   acc_next = acc + 16'd1;
        acc_cpu_pkg::OP_DEC:   acc_next = acc - 16'd1;
        acc_cpu_pkg::OP_JMP:   pc_next  = y;
        acc_cpu_pkg::OP_JZ: begin
          if (acc == 16'd0) begin
            pc_next = y;
          end
        end
        acc_cpu_pkg::OP_LOAD:  acc_next = operand;
        acc_cpu_pkg::OP_STORE: acc_next = acc;
        acc_cpu_pkg::OP_ADD:   acc_next = acc + operand;
        acc_cpu_pkg::OP_AND:   acc_next = acc & operand;
        acc_cpu_pkg::OP_OR:    acc_next = acc | operand;
        acc_cpu_pkg::OP_XOR:   acc_next = acc ^ operand;
        acc_cpu_pkg::OP_PRINT: acc_next = acc;
        acc_cpu_pkg::OP_READ:  acc_next = acc;
        default:               acc_next = acc;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      pc  <= '0;
    end else begin
      acc <= acc_next;
      pc  <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_req) begin
      addr_r <= req_address;
      val_r  <= req_value;
    end
    if (cmd.latch_lo) begin
      lo_byte <= rdata;
    end
    if (cmd.latch_ins) begin
      ins <= {rdata, lo_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.take_req) begin
      halted <= 1'b0;
      pvalid <= 1'b0;
      pfmt   <= acc_cpu_pkg::FMT_HEX;
      rbyte  <= 8'd0;
    end else begin
      if (cmd.exec) begin
        halted <= (op == acc_cpu_pkg::OP_HALT);
        pvalid <= (op == acc_cpu_pkg::OP_PRINT);
        pfmt   <= (op == acc_cpu_pkg::OP_PRINT) ? fmt : acc_cpu_pkg::FMT_HEX;
      end
      if (cmd.cap_rbyte) begin
        rbyte <= rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      acc_value    <= acc;
      pc_value     <= pc;
      halted_out   <= halted;
      print_valid  <= pvalid;
      print_format <= pfmt;
      read_byte    <= rbyte;
    end
  end

  a_halt_keeps_pc: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && op == acc_cpu_pkg::OP_HALT |=> pc == $past(pc))
    else $error("halt changed the program counter");

  a_print_flags: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && op == acc_cpu_pkg::OP_PRINT |=> pvalid && !halted)
    else $error("print did not raise its flag");

  a_flags_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.take_req |=> !halted && !pvalid && rbyte == 8'd0)
    else $error("result flags not cleared for a new request");

endmodule

// File: rtl/acc_cpu_ctrl.sv
// Controller of the accumulator CPU core: sequences RAM clearing, fetch, operand access,
// word writes, byte reads and the result handshake. Uses acc_cpu_pkg.
module acc_cpu_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic [1:0]         req_func,
  output logic               req_ready,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output acc_cpu_pkg::cmd_t  cmd,
  input  acc_cpu_pkg::stat_t stat
);

  acc_cpu_pkg::state_t state, state_next;
  acc_cpu_pkg::func_t  func;
  logic                out_free;
  logic                mem_op;

  assign func     = acc_cpu_pkg::func_t'(req_func);
  assign out_free = !rsp_valid || rsp_ready;
  assign mem_op   = stat.op inside {acc_cpu_pkg::OP_LOAD, acc_cpu_pkg::OP_ADD,
                                    acc_cpu_pkg::OP_AND, acc_cpu_pkg::OP_OR,
                                    acc_cpu_pkg::OP_XOR};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= acc_cpu_pkg::ST_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      acc_cpu_pkg::ST_CLR: begin
        if (stat.clr_last) state_next = acc_cpu_pkg::ST_IDLE;
      end
      acc_cpu_pkg::ST_IDLE: begin
        if (req_valid) begin
          unique case (func)
            acc_cpu_pkg::FN_EXEC:  state_next = acc_cpu_pkg::ST_F0;
            acc_cpu_pkg::FN_WRITE: state_next = acc_cpu_pkg::ST_W0;
            acc_cpu_pkg::FN_READ:  state_next = acc_cpu_pkg::ST_R0;
            acc_cpu_pkg::FN_CLEAR: state_next = acc_cpu_pkg::ST_C0;
            default:               state_next = acc_cpu_pkg::ST_IDLE;
          endcase
        end
      end
      acc_cpu_pkg::ST_F0: state_next = acc_cpu_pkg::ST_F1;
      acc_cpu_pkg::ST_F1: state_next = acc_cpu_pkg::ST_EX;
      acc_cpu_pkg::ST_EX: state_next = acc_cpu_pkg::ST_OP;
      acc_cpu_pkg::ST_OP: begin
        if (mem_op) begin
          state_next = acc_cpu_pkg::ST_L1;
        end else if (stat.op == acc_cpu_pkg::OP_STORE) begin
          state_next = acc_cpu_pkg::ST_S1;
        end else begin
          state_next = acc_cpu_pkg::ST_DONE;
        end
      end
      acc_cpu_pkg::ST_L1: state_next = acc_cpu_pkg::ST_L2;
      acc_cpu_pkg::ST_L2: state_next = acc_cpu_pkg::ST_DONE;
      acc_cpu_pkg::ST_S1: state_next = acc_cpu_pkg::ST_DONE;
      acc_cpu_pkg::ST_W0: state_next = acc_cpu_pkg::ST_W1;
      acc_cpu_pkg::ST_W1: state_next = acc_cpu_pkg::ST_DONE;
      acc_cpu_pkg::ST_R0: state_next = acc_cpu_pkg::ST_R1;
      acc_cpu_pkg::ST_R1: state_next = acc_cpu_pkg::ST_DONE;
      acc_cpu_pkg::ST_C0: state_next = acc_cpu_pkg::ST_DONE;
      acc_cpu_pkg::ST_DONE: begin
        if (out_free) state_next = acc_cpu_pkg::ST_IDLE;
      end
      default: state_next = acc_cpu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.mem_src    = acc_cpu_pkg::MS_PC;
    cmd.wsrc       = acc_cpu_pkg::WS_ZERO;
    unique case (state)
      acc_cpu_pkg::ST_CLR: begin
        cmd.mem_src = acc_cpu_pkg::MS_CLR;
        cmd.mem_we  = 1'b1;
      end
      acc_cpu_pkg::ST_IDLE: cmd.take_req = req_valid;
      acc_cpu_pkg::ST_F0:   cmd.mem_src  = acc_cpu_pkg::MS_PC;
      acc_cpu_pkg::ST_F1: begin
        cmd.mem_src  = acc_cpu_pkg::MS_PC1;
        cmd.latch_lo = 1'b1;
      end
      acc_cpu_pkg::ST_EX:   cmd.latch_ins = 1'b1;
      acc_cpu_pkg::ST_OP: begin
        if (mem_op) begin
          cmd.mem_src = acc_cpu_pkg::MS_Y;
        end else if (stat.op == acc_cpu_pkg::OP_STORE) begin
          cmd.mem_src = acc_cpu_pkg::MS_Y;
          cmd.mem_we  = 1'b1;
          cmd.wsrc    = acc_cpu_pkg::WS_ACC_LO;
        end else begin
          cmd.exec = 1'b1;
        end
      end
      acc_cpu_pkg::ST_L1: begin
        cmd.mem_src  = acc_cpu_pkg::MS_Y1;
        cmd.latch_lo = 1'b1;
      end
      acc_cpu_pkg::ST_L2:   cmd.exec = 1'b1;
      acc_cpu_pkg::ST_S1: begin
        // The high byte goes out before exec updates the accumulator.
        cmd.mem_src = acc_cpu_pkg::MS_Y1;
        cmd.mem_we  = 1'b1;
        cmd.wsrc    = acc_cpu_pkg::WS_ACC_HI;
        cmd.exec    = 1'b1;
      end
      acc_cpu_pkg::ST_W0: begin
        cmd.mem_src = acc_cpu_pkg::MS_ADDR;
        cmd.mem_we  = 1'b1;
        cmd.wsrc    = acc_cpu_pkg::WS_VAL_LO;
      end
      acc_cpu_pkg::ST_W1: begin
        cmd.mem_src = acc_cpu_pkg::MS_ADDR1;
        cmd.mem_we  = 1'b1;
        cmd.wsrc    = acc_cpu_pkg::WS_VAL_HI;
      end
      acc_cpu_pkg::ST_R0:   cmd.mem_src    = acc_cpu_pkg::MS_ADDR;
      acc_cpu_pkg::ST_R1:   cmd.cap_rbyte  = 1'b1;
      acc_cpu_pkg::ST_C0:   cmd.clear_regs = 1'b1;
      acc_cpu_pkg::ST_DONE: cmd.load_out   = out_free;
      default:              cmd.take_req   = 1'b0;
    endcase
  end

  assign req_ready = (state == acc_cpu_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!rsp_valid || rsp_ready))
    else $error("result register overwritten before it was taken");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second request taken while one is in progress");

  a_no_write_on_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.mem_we |-> !req_ready)
    else $error("RAM written while the request side is open");

endmodule

// File: sim/accumulator_cpu_core_tb.sv
// Self-checking testbench for accumulator_cpu_core: drives requests, mirrors the machine state
// and compares every result. Depends on acc_cpu_pkg, acc_cpu_req_if and acc_cpu_rsp_if.
`timescale 1ns / 100ps

module accumulator_cpu_core_tb;

  localparam int MEM_BYTES      = 4096;
  localparam int RANDOM_ITEMS   = 2000;
  localparam int CALM_ITEMS     = 300;
  localparam int LONG_HOLD      = 250;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [15:0] acc_value;
    logic [11:0] pc_value;
    logic        halted;
    logic        print_valid;
    logic [1:0]  print_format;
    logic [7:0]  read_byte;
  } cpu_outcome_t;

  // Mirror of the machine: RAM, accumulator and PC, plus the outcomes still owed by the core.
  class machine_mirror;
    logic [7:0]   ram[MEM_BYTES];
    logic [15:0]  acc_now;
    logic [11:0]  pc_now;
    cpu_outcome_t owed_outcomes[$];
    int           per_func[4];
    int           prints;
    int           halts;
    int           mismatches;

    function new();
      foreach (ram[i]) ram[i] = 8'h00;
      acc_now    = '0;
      pc_now     = '0;
      prints     = 0;
      halts      = 0;
      mismatches = 0;
      foreach (per_func[i]) per_func[i] = 0;
    endfunction

    function int pending();
      return owed_outcomes.size();
    endfunction

    function int ram_index(logic [11:0] a);
      return int'(a) % MEM_BYTES;
    endfunction

    function logic [15:0] fetch_word(logic [11:0] a);
      logic [11:0] a_hi;
      a_hi = a + 12'd1;
      return {ram[ram_index(a_hi)], ram[ram_index(a)]};
    endfunction

    function void put_word(logic [11:0] a, logic [15:0] w);
      logic [11:0] a_hi;
      a_hi = a + 12'd1;
      ram[ram_index(a)]    = w[7:0];
      ram[ram_index(a_hi)] = w[15:8];
    endfunction

    function void apply_request(acc_cpu_pkg::func_t f, logic [11:0] a, logic [15:0] v);
      cpu_outcome_t     o;
      logic [15:0]      ins;
      acc_cpu_pkg::op_t op;
      logic [11:0]      y;
      o = '0;
      per_func[int'(f)]++;
      case (f)
        acc_cpu_pkg::FN_EXEC: begin
          ins = fetch_word(pc_now);
          op  = acc_cpu_pkg::op_t'(ins[15:12]);
          y   = ins[11:0];
          if (op != acc_cpu_pkg::OP_HALT) pc_now = pc_now + 12'd2;
          case (op)
            acc_cpu_pkg::OP_HALT: begin
              o.halted = 1'b1;
              halts++;
            end
            acc_cpu_pkg::OP_NOT:   acc_now = ~acc_now;
            acc_cpu_pkg::OP_SHL:   acc_now = (y >= 12'd16) ? 16'h0000 : acc_now << y;
            acc_cpu_pkg::OP_SHR:   acc_now = (y >= 12'd16) ? 16'h0000 : acc_now >> y;
            acc_cpu_pkg::OP_INC:   acc_now = acc_now + 16'd1;
            acc_cpu_pkg::OP_DEC:   acc_now = acc_now - 16'd1;
            acc_cpu_pkg::OP_JMP:   pc_now = y;
            acc_cpu_pkg::OP_JZ:    if (acc_now == 16'h0000) pc_now = y;
            acc_cpu_pkg::OP_LOAD:  acc_now = fetch_word(y);
            acc_cpu_pkg::OP_STORE: put_word(y, acc_now);
            acc_cpu_pkg::OP_ADD:   acc_now = acc_now + fetch_word(y);
            acc_cpu_pkg::OP_AND:   acc_now = acc_now & fetch_word(y);
            acc_cpu_pkg::OP_OR:    acc_now = acc_now | fetch_word(y);
            acc_cpu_pkg::OP_XOR:   acc_now = acc_now ^ fetch_word(y);
            acc_cpu_pkg::OP_PRINT: begin
              o.print_valid  = 1'b1;
              o.print_format = (y == acc_cpu_pkg::Y_FMT_DEC)  ? acc_cpu_pkg::FMT_DEC :
                               (y == acc_cpu_pkg::Y_FMT_CHAR) ? acc_cpu_pkg::FMT_CHAR :
                               acc_cpu_pkg::FMT_HEX;
              prints++;
            end
            default: ;
          endcase
        end
        acc_cpu_pkg::FN_WRITE: put_word(a, v);
        acc_cpu_pkg::FN_READ:  o.read_byte = ram[ram_index(a)];
        default: begin
          acc_now = '0;
          pc_now  = '0;
        end
      endcase
      o.acc_value = acc_now;
      o.pc_value  = pc_now;
      owed_outcomes.push_back(o);
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        mismatches++;
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      end
    endfunction

    function void compare_outcome(cpu_outcome_t got);
      cpu_outcome_t want;
      if (owed_outcomes.size() == 0) begin
        mismatches++;
        $error("result arrived with no request outstanding");
        return;
      end
      want = owed_outcomes.pop_front();
      check_field("acc_value", want.acc_value, got.acc_value);
      check_field("pc_value", 16'(want.pc_value), 16'(got.pc_value));
      check_field("halted", 16'(want.halted), 16'(got.halted));
      check_field("print_valid", 16'(want.print_valid), 16'(got.print_valid));
      check_field("print_format", 16'(want.print_format), 16'(got.print_format));
      check_field("read_byte", 16'(want.read_byte), 16'(got.read_byte));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  acc_cpu_req_if req_ch ();
  acc_cpu_rsp_if rsp_ch ();

  accumulator_cpu_core #(
    .MEM_BYTES(MEM_BYTES)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  machine_mirror mirror;
  int            sent;
  int            gap_pct;
  int            stall_pct;
  int            hold_off_len = 0;
  int            quiet_cycles = 0;
  logic [11:0]   data_spots[8];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result side: random stalls, plus one long hold-off requested by the main sequence.
  initial begin
    bit hold_done;
    hold_done    = 1'b0;
    rsp_ch.ready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_off_len > 0 && !hold_done) begin
        hold_done    = 1'b1;
        rsp_ch.ready = 1'b0;
        repeat (hold_off_len - 1) @(negedge clk);
      end else if (stall_pct > 0 && $urandom_range(1, 100) <= stall_pct) begin
        rsp_ch.ready = 1'b0;
        repeat ($urandom_range(0, 2)) @(negedge clk);
      end else begin
        rsp_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      mirror.compare_outcome({rsp_ch.acc_value, rsp_ch.pc_value, rsp_ch.halted,
                              rsp_ch.print_valid, rsp_ch.print_format, rsp_ch.read_byte});
  end

  // The reset sweep of the RAM counts as quiet time, so the limit sits well above it.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("Timeout: nothing moved for %0d cycles", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Offers one request and returns once it has been taken; the mirror is updated at that edge.
  task automatic issue(acc_cpu_pkg::func_t f, logic [11:0] a, logic [15:0] v);
    int unsigned gap;
    if (gap_pct > 0 && $urandom_range(1, 100) <= gap_pct) begin
      gap = $urandom_range(1, 3);
      @(negedge clk);
      req_ch.valid   = 1'b0;
      req_ch.func    = acc_cpu_pkg::func_t'($urandom_range(0, 3));
      req_ch.address = 12'($urandom_range(0, 4095));
      req_ch.value   = 16'($urandom_range(0, 65535));
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid   = 1'b1;
    req_ch.func    = f;
    req_ch.address = a;
    req_ch.value   = v;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    mirror.apply_request(f, a, v);
    sent++;
  endtask

  // The request side goes idle first so that the last request is not offered again.
  task automatic wait_all_results();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (mirror.pending() != 0) @(negedge clk);
  endtask

  function automatic logic [15:0] ins(acc_cpu_pkg::op_t op, logic [11:0] y);
    return {op, y};
  endfunction

  function automatic logic [11:0] any_addr();
    return 12'($urandom_range(0, 4095));
  endfunction

  function automatic logic [15:0] data_word();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Operands are steered towards the program itself and a few data words so that jumps,
  // loads and stores mostly land on something that was written.
  function automatic logic [15:0] random_instruction(logic [11:0] base, int len);
    acc_cpu_pkg::op_t op;
    logic [11:0]      y;
    op = acc_cpu_pkg::op_t'($urandom_range(0, 15));
    if (op == acc_cpu_pkg::OP_HALT && $urandom_range(0, 2) != 0) op = acc_cpu_pkg::OP_INC;
    case (op)
      acc_cpu_pkg::OP_SHL, acc_cpu_pkg::OP_SHR:
        y = ($urandom_range(0, 3) == 0) ? any_addr() : 12'($urandom_range(0, 17));
      acc_cpu_pkg::OP_JMP, acc_cpu_pkg::OP_JZ:
        y = ($urandom_range(0, 3) == 0) ? any_addr() :
            base + 12'(2 * $urandom_range(0, len));
      acc_cpu_pkg::OP_LOAD, acc_cpu_pkg::OP_STORE, acc_cpu_pkg::OP_ADD,
      acc_cpu_pkg::OP_AND, acc_cpu_pkg::OP_OR, acc_cpu_pkg::OP_XOR:
        y = ($urandom_range(0, 3) == 0) ? any_addr() : data_spots[$urandom_range(0, 7)];
      acc_cpu_pkg::OP_PRINT:
        y = ($urandom_range(0, 1) == 0) ? 12'($urandom_range(0, 3)) : any_addr();
      default:
        y = any_addr();
    endcase
    return ins(op, y);
  endfunction

  // A short program is written at the current PC together with some data, then run.
  task automatic run_program();
    logic [11:0] base;
    int          len;
    int          steps;
    if ($urandom_range(0, 3) == 0) issue(acc_cpu_pkg::FN_CLEAR, any_addr(), data_word());
    repeat ($urandom_range(0, 3))
      issue(acc_cpu_pkg::FN_WRITE, data_spots[$urandom_range(0, 7)], data_word());
    base  = mirror.pc_now;
    len   = $urandom_range(1, 6);
    steps = len + $urandom_range(0, 3);
    for (int i = 0; i < len; i++)
      issue(acc_cpu_pkg::FN_WRITE, base + 12'(2 * i), random_instruction(base, len));
    repeat (steps) issue(acc_cpu_pkg::FN_EXEC, any_addr(), data_word());
    if ($urandom_range(0, 2) == 0) begin
      issue(acc_cpu_pkg::FN_READ,
            ($urandom_range(0, 1) == 0) ? any_addr() : data_spots[$urandom_range(0, 7)],
            data_word());
    end
    if ($urandom_range(0, 3) == 0)
      issue(acc_cpu_pkg::func_t'($urandom_range(0, 3)), any_addr(), data_word());
  endtask

  initial begin
    bit held;
    bit drained;
    mirror         = new();
    sent           = 0;
    gap_pct        = 20;
    stall_pct      = 20;
    held           = 1'b0;
    drained        = 1'b0;
    req_ch.valid   = 1'b0;
    req_ch.func    = acc_cpu_pkg::FN_EXEC;
    req_ch.address = '0;
    req_ch.value   = '0;
    data_spots[0]  = 12'hFFF;
    data_spots[1]  = 12'h000;
    for (int i = 2; i < 8; i++) data_spots[i] = any_addr();

    repeat (12) @(negedge clk);
    rst = 1'b0;

    // Word written across the top of the RAM lands its high byte at address zero.
    issue(acc_cpu_pkg::FN_WRITE, 12'hFFF, 16'hA55A);
    issue(acc_cpu_pkg::FN_READ, 12'hFFF, 16'h0000);
    issue(acc_cpu_pkg::FN_READ, 12'h000, 16'hFFFF);
    issue(acc_cpu_pkg::FN_WRITE, 12'h000, ins(acc_cpu_pkg::OP_LOAD, 12'hFFF));
    issue(acc_cpu_pkg::FN_WRITE, 12'h002, ins(acc_cpu_pkg::OP_SHL, 12'd4));
    issue(acc_cpu_pkg::FN_WRITE, 12'h004, ins(acc_cpu_pkg::OP_SHR, 12'd16));
    issue(acc_cpu_pkg::FN_WRITE, 12'h006, ins(acc_cpu_pkg::OP_JZ, 12'h00A));
    issue(acc_cpu_pkg::FN_WRITE, 12'h00A, ins(acc_cpu_pkg::OP_PRINT, acc_cpu_pkg::Y_FMT_DEC));
    issue(acc_cpu_pkg::FN_WRITE, 12'h00C, ins(acc_cpu_pkg::OP_PRINT, acc_cpu_pkg::Y_FMT_CHAR));
    issue(acc_cpu_pkg::FN_WRITE, 12'h00E, ins(acc_cpu_pkg::OP_STORE, 12'hFFF));
    issue(acc_cpu_pkg::FN_WRITE, 12'h010, ins(acc_cpu_pkg::OP_HALT, 12'hFFF));
    repeat (9) issue(acc_cpu_pkg::FN_EXEC, 12'hFFF, 16'hFFFF);
    issue(acc_cpu_pkg::FN_READ, 12'h000, 16'h0000);
    issue(acc_cpu_pkg::FN_READ, 12'hFFF, 16'h0000);
    issue(acc_cpu_pkg::FN_READ, 12'h001, 16'h0000);
    issue(acc_cpu_pkg::FN_CLEAR, 12'hFFF, 16'hFFFF);
    issue(acc_cpu_pkg::FN_EXEC, 12'h000, 16'h0000);

    while (sent < 25 + RANDOM_ITEMS) begin
      if (sent > 25 + RANDOM_ITEMS - CALM_ITEMS) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else if ($urandom_range(0, 3) == 0) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = $urandom_range(5, 50);
        stall_pct = $urandom_range(5, 50);
      end
      if (!held && sent > 600) begin
        held         = 1'b1;
        hold_off_len = LONG_HOLD;
        repeat (4) issue(acc_cpu_pkg::FN_EXEC, any_addr(), data_word());
      end
      if (!drained && sent > 1200) begin
        drained = 1'b1;
        wait_all_results();
      end
      run_program();
    end

    @(negedge clk);
    req_ch.valid = 1'b0;
    wait_all_results();
    repeat (10) @(negedge clk);

    $display("Sent %0d requests: %0d executed, %0d word writes, %0d byte reads, %0d clears.",
             sent, mirror.per_func[acc_cpu_pkg::FN_EXEC], mirror.per_func[acc_cpu_pkg::FN_WRITE],
             mirror.per_func[acc_cpu_pkg::FN_READ], mirror.per_func[acc_cpu_pkg::FN_CLEAR]);
    $display("Prints seen: %0d, halts seen: %0d, mismatches: %0d.",
             mirror.prints, mirror.halts, mirror.mismatches);
    if (mirror.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/acc_cpu_pkg.sv
rtl/acc_cpu_req_if.sv
rtl/acc_cpu_rsp_if.sv
rtl/acc_cpu_dp.sv
rtl/acc_cpu_ctrl.sv
rtl/accumulator_cpu_core.sv
sim/accumulator_cpu_core_tb.sv
